### sv/tbp_pkg.sv
package tbp_pkg;

  localparam int LOCAL_INDEX_BITS    = 10;
  localparam int GLOBAL_HISTORY_BITS = 12;
  localparam int CLEAR_BITS = (LOCAL_INDEX_BITS > GLOBAL_HISTORY_BITS) ?
                              LOCAL_INDEX_BITS : GLOBAL_HISTORY_BITS;

  localparam int LOCAL_DEPTH  = 1 << LOCAL_INDEX_BITS;
  localparam int GLOBAL_DEPTH = 1 << GLOBAL_HISTORY_BITS;

  localparam int LCTR_BITS = 3;
  localparam int GCTR_BITS = 2;
  localparam int LWORD_BITS = LOCAL_INDEX_BITS + LCTR_BITS;
  localparam int GWORD_BITS = 2 * GCTR_BITS;

  localparam logic [LCTR_BITS-1:0] LCTR_MAX = '1;
  localparam logic [GCTR_BITS-1:0] GCTR_MAX = '1;

  localparam int PC_BITS      = 64;
  localparam int PC_IDX_LSB   = 2;
  localparam int IN_DATA_BITS = 72;
  localparam int OUT_DATA_BITS = 8;

  localparam logic [1:0] MODE_CHOOSER = 2'd0;
  localparam logic [1:0] MODE_LOCAL   = 2'd1;

  localparam logic KIND_PREDICT = 1'b0;
  localparam logic KIND_UPDATE  = 1'b1;

endpackage

### sv/tournament_branch_predictor.sv
// Tournament branch predictor (local history, global history, chooser).
//
// Input stream s_*: s_tuser is the kind (0 predict, 1 update); s_tdata holds
// pc, actual_taken, local_was_taken, global_was_taken from bit 0 up.
// Output stream m_*: one transaction per input transaction, in order;
// m_tdata holds predict_taken, local_says_taken, global_says_taken,
// choice_global from bit 0 up. Updates return all zeros. The user must
// write predict_mode through cfg_we/cfg_wdata only while the block is
// idle; the block itself does not enforce this.
// Each item does two dependent reads of the local memory (history, then
// counter): the history is read on acceptance and the counter in S_HIST,
// and S_CTR registers the result in m_tdata and m_tvalid. A predict then
// returns to S_IDLE; an update passes through S_HWR, which writes the
// history back through the same memory port. One item is in flight at a
// time. The result sits in an output register; a stalled receiver holds
// the item in S_CTR until the register frees, and no new transaction is
// taken in the meantime.
// After rst, a clearing pass zeroes both memories over 2^max(local index
// bits, global history bits) = 4096 addresses, with s_tready low.
module tournament_branch_predictor (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [1:0]                          cfg_wdata,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // pc[63:0], actual_taken, local_was_taken, global_was_taken, zero pad
  input  logic [tbp_pkg::IN_DATA_BITS-1:0]    s_tdata,
  // kind
  input  logic                                s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // predict_taken, local_says_taken, global_says_taken, choice_global, pad
  output logic [tbp_pkg::OUT_DATA_BITS-1:0]   m_tdata
);

  localparam int L  = tbp_pkg::LOCAL_INDEX_BITS;
  localparam int G  = tbp_pkg::GLOBAL_HISTORY_BITS;
  localparam int LC = tbp_pkg::LCTR_BITS;
  localparam int GC = tbp_pkg::GCTR_BITS;
  localparam int PW = tbp_pkg::PC_BITS;

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_HIST, S_CTR, S_HWR} state_t;

  state_t                      state;
  logic [1:0]                  mode;
  logic [tbp_pkg::CLEAR_BITS-1:0] clr_addr;
  logic [G-1:0]                ghist;

  logic                        kind_r;
  logic [L-1:0]                hidx;
  logic [L-1:0]                cidx;
  logic                        taken;
  logic                        lwas;
  logic                        gwas;
  logic [L-1:0]                hword_hist;
  logic [LC-1:0]               hword_ctr;
  logic [LC-1:0]               lctr_new;
  logic [GC-1:0]               gctr;
  logic [GC-1:0]               chctr;

  logic [tbp_pkg::LWORD_BITS-1:0] lmem [tbp_pkg::LOCAL_DEPTH];
  logic [tbp_pkg::GWORD_BITS-1:0] gmem [tbp_pkg::GLOBAL_DEPTH];
  logic [tbp_pkg::LWORD_BITS-1:0] lrd;
  logic [tbp_pkg::GWORD_BITS-1:0] grd;

  logic                        lre;
  logic [L-1:0]                lraddr;
  logic                        lwe;
  logic [L-1:0]                lwaddr;
  logic [tbp_pkg::LWORD_BITS-1:0] lwdata;
  logic                        gre;
  logic                        gwe;
  logic [G-1:0]                gwaddr;
  logic [tbp_pkg::GWORD_BITS-1:0] gwdata;

  logic                        accept;
  logic                        out_free;
  logic [LC-1:0]               lctr_cur;
  logic [LC-1:0]               lctr_calc;
  logic [GC-1:0]               gctr_calc;
  logic [GC-1:0]               chctr_calc;
  logic                        lsay;
  logic                        gsay;
  logic                        chs;
  logic                        pred;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign lctr_cur = lrd[LC-1:0];

  always_comb begin
    lctr_calc = taken ? ((lctr_cur == tbp_pkg::LCTR_MAX) ? lctr_cur : lctr_cur + 1'b1)
                      : ((lctr_cur == '0) ? lctr_cur : lctr_cur - 1'b1);
    gctr_calc = taken ? ((gctr == tbp_pkg::GCTR_MAX) ? gctr : gctr + 1'b1)
                      : ((gctr == '0) ? gctr : gctr - 1'b1);
    chctr_calc = chctr;
    if (taken == lwas && taken != gwas) begin
      chctr_calc = (chctr == '0) ? chctr : chctr - 1'b1;
    end else if (taken != lwas && taken == gwas) begin
      chctr_calc = (chctr == tbp_pkg::GCTR_MAX) ? chctr : chctr + 1'b1;
    end

    lsay = 1'b0;
    gsay = 1'b0;
    chs  = 1'b0;
    if (kind_r == tbp_pkg::KIND_PREDICT && !mode[1]) begin
      lsay = lctr_cur[LC-1];
      if (mode == tbp_pkg::MODE_CHOOSER) begin
        gsay = gctr[GC-1];
        chs  = chctr[GC-1];
      end
    end
    pred = (lsay != gsay) ? (chs ? gsay : lsay) : lsay;
  end

  // memory port control
  always_comb begin
    lre    = 1'b0;
    lraddr = hidx;
    gre    = 1'b0;
    lwe    = 1'b0;
    lwaddr = cidx;
    lwdata = {lrd[tbp_pkg::LWORD_BITS-1:LC], lctr_calc};
    gwe    = 1'b0;
    gwaddr = ghist;
    gwdata = {gctr_calc, chctr_calc};
    case (state)
      S_CLEAR: begin
        lwe    = 1'b1;
        lwaddr = clr_addr[L-1:0];
        lwdata = '0;
        gwe    = 1'b1;
        gwaddr = clr_addr[G-1:0];
        gwdata = '0;
      end
      S_IDLE: begin
        lre    = accept;
        lraddr = s_tdata[tbp_pkg::PC_IDX_LSB +: L];
        gre    = accept;
      end
      S_HIST: begin
        lre    = 1'b1;
        lraddr = lrd[tbp_pkg::LWORD_BITS-1:LC];
      end
      S_CTR: begin
        lwe = out_free && (kind_r == tbp_pkg::KIND_UPDATE);
        gwe = out_free && (kind_r == tbp_pkg::KIND_UPDATE);
      end
      S_HWR: begin
        lwe    = 1'b1;
        lwaddr = hidx;
        lwdata = {hword_hist[L-2:0], taken, (hidx == cidx) ? lctr_new : hword_ctr};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (lwe) begin
      lmem[lwaddr] <= lwdata;
    end
    if (lre) begin
      lrd <= lmem[lraddr];
    end
  end

  always_ff @(posedge clk) begin
    if (gwe) begin
      gmem[gwaddr] <= gwdata;
    end
    if (gre) begin
      grd <= gmem[ghist];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      mode     <= tbp_pkg::MODE_CHOOSER;
      ghist    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_we) begin
        mode <= cfg_wdata;
      end
      if (m_tvalid && m_tready && !(state == S_CTR && out_free)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == '1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            kind_r <= s_tuser;
            hidx   <= s_tdata[tbp_pkg::PC_IDX_LSB +: L];
            taken  <= s_tdata[PW];
            lwas   <= s_tdata[PW+1];
            gwas   <= s_tdata[PW+2];
            state  <= S_HIST;
          end
        end
        S_HIST: begin
          cidx       <= lrd[tbp_pkg::LWORD_BITS-1:LC];
          hword_hist <= lrd[tbp_pkg::LWORD_BITS-1:LC];
          hword_ctr  <= lrd[LC-1:0];
          gctr       <= grd[tbp_pkg::GWORD_BITS-1:GC];
          chctr      <= grd[GC-1:0];
          state      <= S_CTR;
        end
        S_CTR: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {{(tbp_pkg::OUT_DATA_BITS-4){1'b0}}, chs, gsay, lsay, pred};
            if (kind_r == tbp_pkg::KIND_UPDATE) begin
              lctr_new <= lctr_calc;
              ghist    <= {ghist[G-2:0], taken};
              state    <= S_HWR;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_HWR: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_no_output_while_clearing: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !m_tvalid)
    else $error("result presented during clearing pass");

  a_clear_writes_both: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> (lwe && gwe))
    else $error("clearing pass skipped a memory write");

  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (!lwe && !gwe))
    else $error("memory write while idle");

  a_ghist_only_on_update: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && ghist != $past(ghist)) |->
      ($past(state == S_CTR) && $past(kind_r == tbp_pkg::KIND_UPDATE)))
    else $error("global history changed outside an update");

endmodule

### dv/tournament_branch_predictor_test.sv
module tournament_branch_predictor_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] MODE_FALL_LO = 2'd2;
  localparam logic [1:0] MODE_FALL_HI = 2'd3;

  localparam int POOL_SIZE       = 8;
  localparam int ITEMS_PER_PHASE = 200;
  localparam int NUM_ROWS        = 21;
  localparam int REPORT_LIMIT    = 10;
  localparam int CYCLE_LIMIT     = 600000;
  localparam int PAD_BITS        = tbp_pkg::IN_DATA_BITS - tbp_pkg::PC_BITS - 3;

  localparam logic [tbp_pkg::PC_BITS-1:0] PC_ONES = '1;
  localparam logic [tbp_pkg::PC_BITS-1:0] PC_ALTA = 64'hAAAA_AAAA_AAAA_AAAA;
  localparam logic [tbp_pkg::PC_BITS-1:0] PC_ALT5 = 64'h5555_5555_5555_5555;

  typedef struct packed {
    logic                        kind;
    logic [tbp_pkg::PC_BITS-1:0] pc;
    logic                        taken;
    logic                        lwas;
    logic                        gwas;
  } branch_item_t;

  // bit 0 up: predict_taken, local_says_taken, global_says_taken, choice_global
  typedef struct packed {
    logic choice_global;
    logic global_says_taken;
    logic local_says_taken;
    logic predict_taken;
  } bp_result_t;

  typedef struct packed {
    logic [1:0]   mode;
    branch_item_t item;
    logic         typed;
    bp_result_t   want;
  } stim_row_t;

  localparam bp_result_t ZERO_RES = '0;

  logic                              clk;
  logic                              rst = 1'b1;
  logic                              cfg_we = 1'b0;
  logic [1:0]                        cfg_wdata = '0;
  logic                              s_tvalid = 1'b0;
  logic                              s_tready;
  logic [tbp_pkg::IN_DATA_BITS-1:0]  s_tdata = '0;
  logic                              s_tuser = 1'b0;
  logic                              m_tvalid;
  logic                              m_tready = 1'b0;
  logic [tbp_pkg::OUT_DATA_BITS-1:0] m_tdata;

  tournament_branch_predictor DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  // predictor state
  logic [tbp_pkg::LOCAL_INDEX_BITS-1:0]    local_hist [tbp_pkg::LOCAL_DEPTH];
  logic [tbp_pkg::LCTR_BITS-1:0]           local_ctr  [tbp_pkg::LOCAL_DEPTH];
  logic [tbp_pkg::GCTR_BITS-1:0]           global_ctr [tbp_pkg::GLOBAL_DEPTH];
  logic [tbp_pkg::GCTR_BITS-1:0]           choice_ctr [tbp_pkg::GLOBAL_DEPTH];
  logic [tbp_pkg::GLOBAL_HISTORY_BITS-1:0] path_hist;
  logic [1:0]                              model_mode;

  bp_result_t  awaited_predictions [$];
  logic        quiet = 1'b0;
  int unsigned ready_hold = 0;
  int unsigned cycles = 0;
  int unsigned mismatches = 0;
  int unsigned n_predicts = 0;
  int unsigned n_updates = 0;
  int unsigned n_taken_preds = 0;
  int unsigned n_mode_writes = 0;

  stim_row_t dir_rows [NUM_ROWS] = '{
    '{tbp_pkg::MODE_CHOOSER, '{tbp_pkg::KIND_PREDICT, 64'h0,  1'b0, 1'b0, 1'b0}, 1'b1, ZERO_RES},
    '{tbp_pkg::MODE_CHOOSER, '{tbp_pkg::KIND_PREDICT, PC_ONES, 1'b1, 1'b1, 1'b1}, 1'b1, ZERO_RES},
    '{tbp_pkg::MODE_CHOOSER, '{tbp_pkg::KIND_UPDATE,  PC_ONES, 1'b1, 1'b0, 1'b1}, 1'b1, ZERO_RES},
    '{tbp_pkg::MODE_CHOOSER, '{tbp_pkg::KIND_UPDATE,  PC_ONES, 1'b1, 1'b0, 1'b1}, 1'b1, ZERO_RES},
    '{tbp_pkg::MODE_CHOOSER, '{tbp_pkg::KIND_PREDICT, PC_ONES, 1'b0, 1'b0, 1'b0}, 1'b0, ZERO_RES},
    '{tbp_pkg::MODE_CHOOSER, '{tbp_pkg::KIND_UPDATE,  64'h4,  1'b1, 1'b1, 1'b0}, 1'b1, ZERO_RES},
    '{tbp_pkg::MODE_CHOOSER, '{tbp_pkg::KIND_UPDATE,  64'h4,  1'b0, 1'b0, 1'b0}, 1'b1, ZERO_RES},
    '{tbp_pkg::MODE_CHOOSER, '{tbp_pkg::KIND_UPDATE,  64'h4,  1'b1, 1'b1, 1'b1}, 1'b1, ZERO_RES},
    '{tbp_pkg::MODE_CHOOSER, '{tbp_pkg::KIND_UPDATE,  PC_ALTA, 1'b1, 1'b0, 1'b1}, 1'b1, ZERO_RES},
    '{tbp_pkg::MODE_CHOOSER, '{tbp_pkg::KIND_PREDICT, PC_ALT5, 1'b0, 1'b0, 1'b0}, 1'b0, ZERO_RES},
    '{tbp_pkg::MODE_CHOOSER, '{tbp_pkg::KIND_PREDICT, PC_ALTA, 1'b0, 1'b0, 1'b0}, 1'b0, ZERO_RES},
    '{tbp_pkg::MODE_LOCAL,   '{tbp_pkg::KIND_PREDICT, PC_ONES, 1'b0, 1'b0, 1'b0}, 1'b0, ZERO_RES},
    '{tbp_pkg::MODE_LOCAL,   '{tbp_pkg::KIND_UPDATE,  PC_ONES, 1'b1, 1'b1, 1'b0}, 1'b1, ZERO_RES},
    '{tbp_pkg::MODE_LOCAL,   '{tbp_pkg::KIND_PREDICT, 64'h0,  1'b0, 1'b0, 1'b0}, 1'b0, ZERO_RES},
    '{MODE_FALL_LO, '{tbp_pkg::KIND_PREDICT, PC_ONES, 1'b0, 1'b0, 1'b0}, 1'b1, ZERO_RES},
    '{MODE_FALL_LO, '{tbp_pkg::KIND_UPDATE,  64'h0,  1'b1, 1'b0, 1'b1}, 1'b1, ZERO_RES},
    '{MODE_FALL_HI, '{tbp_pkg::KIND_PREDICT, PC_ALTA, 1'b1, 1'b1, 1'b1}, 1'b1, ZERO_RES},
    '{MODE_FALL_HI, '{tbp_pkg::KIND_UPDATE,  PC_ONES, 1'b1, 1'b1, 1'b1}, 1'b1, ZERO_RES},
    '{tbp_pkg::MODE_CHOOSER, '{tbp_pkg::KIND_PREDICT, PC_ONES, 1'b0, 1'b0, 1'b0}, 1'b0, ZERO_RES},
    '{tbp_pkg::MODE_CHOOSER, '{tbp_pkg::KIND_PREDICT, 64'h0,  1'b0, 1'b0, 1'b0}, 1'b0, ZERO_RES},
    '{tbp_pkg::MODE_CHOOSER, '{tbp_pkg::KIND_UPDATE,  PC_ALT5, 1'b0, 1'b1, 1'b1}, 1'b1, ZERO_RES}
  };

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  function automatic void clear_predictor();
    for (int i = 0; i < tbp_pkg::LOCAL_DEPTH; i++) begin
      local_hist[i] = '0;
      local_ctr[i]  = '0;
    end
    for (int i = 0; i < tbp_pkg::GLOBAL_DEPTH; i++) begin
      global_ctr[i] = '0;
      choice_ctr[i] = '0;
    end
    path_hist  = '0;
    model_mode = tbp_pkg::MODE_CHOOSER;
  endfunction

  // Works out the result of one transaction and trains the tables on updates.
  function automatic bp_result_t predict_and_train(input branch_item_t it);
    logic [tbp_pkg::LOCAL_INDEX_BITS-1:0]    hidx;
    logic [tbp_pkg::LOCAL_INDEX_BITS-1:0]    cidx;
    logic [tbp_pkg::GLOBAL_HISTORY_BITS-1:0] gidx;
    bp_result_t                              res;
    hidx = it.pc[tbp_pkg::PC_IDX_LSB +: tbp_pkg::LOCAL_INDEX_BITS];
    cidx = local_hist[hidx];
    gidx = path_hist;
    res  = '0;
    if (it.kind == tbp_pkg::KIND_PREDICT) begin
      if (model_mode == tbp_pkg::MODE_CHOOSER || model_mode == tbp_pkg::MODE_LOCAL) begin
        res.local_says_taken = (local_ctr[cidx] >= 3'd4);
        if (model_mode == tbp_pkg::MODE_CHOOSER) begin
          res.global_says_taken = (global_ctr[gidx] >= 2'd2);
          res.choice_global     = (choice_ctr[gidx] >= 2'd2);
        end
        if (res.local_says_taken != res.global_says_taken && res.choice_global)
          res.predict_taken = res.global_says_taken;
        else
          res.predict_taken = res.local_says_taken;
      end
    end else begin
      // chooser moves only when exactly one side was right
      if (it.taken == it.lwas && it.taken != it.gwas) begin
        if (choice_ctr[gidx] != '0) choice_ctr[gidx] = choice_ctr[gidx] - 1'b1;
      end else if (it.taken != it.lwas && it.taken == it.gwas) begin
        if (choice_ctr[gidx] != tbp_pkg::GCTR_MAX) choice_ctr[gidx] = choice_ctr[gidx] + 1'b1;
      end
      if (it.taken) begin
        if (local_ctr[cidx] != tbp_pkg::LCTR_MAX) local_ctr[cidx] = local_ctr[cidx] + 1'b1;
        if (global_ctr[gidx] != tbp_pkg::GCTR_MAX) global_ctr[gidx] = global_ctr[gidx] + 1'b1;
      end else begin
        if (local_ctr[cidx] != '0) local_ctr[cidx] = local_ctr[cidx] - 1'b1;
        if (global_ctr[gidx] != '0) global_ctr[gidx] = global_ctr[gidx] - 1'b1;
      end
      local_hist[hidx] = {local_hist[hidx][tbp_pkg::LOCAL_INDEX_BITS-2:0], it.taken};
      path_hist        = {path_hist[tbp_pkg::GLOBAL_HISTORY_BITS-2:0], it.taken};
    end
    return res;
  endfunction

  // Sends one transaction; the expectation is taken at the accepting edge.
  task automatic push_branch(input branch_item_t it, input logic typed,
                             input bp_result_t want, output bp_result_t seen);
    int unsigned gap;
    bp_result_t  pred;
    gap = quiet ? 0 : pick_gap();
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= it.kind;
    s_tdata  <= {{PAD_BITS{1'b0}}, it.gwas, it.lwas, it.taken, it.pc};
    do @(posedge clk); while (!s_tready);
    pred = predict_and_train(it);
    awaited_predictions.push_back(typed ? want : pred);
    seen = pred;
    if (it.kind == tbp_pkg::KIND_PREDICT) begin
      n_predicts++;
      if (pred.predict_taken) n_taken_preds++;
    end else begin
      n_updates++;
    end
  endtask

  task automatic drain_block(input int unsigned settle);
    s_tvalid <= 1'b0;
    while (awaited_predictions.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic set_mode(input logic [1:0] mode_val);
    drain_block(8);
    cfg_we    <= 1'b1;
    cfg_wdata <= mode_val;
    @(posedge clk);
    cfg_we     <= 1'b0;
    model_mode = mode_val;
    n_mode_writes++;
  endtask

  // receiver stalls
  always @(posedge clk) begin
    if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else if (quiet) begin
      m_tready <= 1'b1;
    end else begin
      m_tready   <= ($urandom_range(0, 2) != 0);
      ready_hold <= pick_gap();
    end
  end

  always @(posedge clk) begin
    bp_result_t got;
    bp_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = bp_result_t'(m_tdata[3:0]);
      if (awaited_predictions.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("[%0t] result transaction with nothing outstanding: %b", $realtime, got);
      end else begin
        want = awaited_predictions.pop_front();
        if (got.predict_taken != want.predict_taken ||
            got.local_says_taken != want.local_says_taken ||
            got.global_says_taken != want.global_says_taken ||
            got.choice_global != want.choice_global) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("[%0t] mismatch: exp pt=%b ls=%b gs=%b cg=%b, got pt=%b ls=%b gs=%b cg=%b",
                     $realtime, want.predict_taken, want.local_says_taken,
                     want.global_says_taken, want.choice_global, got.predict_taken,
                     got.local_says_taken, got.global_says_taken, got.choice_global);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycles, awaited_predictions.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    logic [tbp_pkg::PC_BITS-1:0] pc_pool [POOL_SIZE];
    int unsigned                 periods [POOL_SIZE];
    int unsigned                 trips [POOL_SIZE];
    logic [1:0]                  phase_modes [6];
    branch_item_t                it;
    bp_result_t                  seen;
    int unsigned                 n;
    int unsigned                 slot;
    int unsigned                 sat_local;
    int unsigned                 sat_global;
    logic                        outcome;

    phase_modes = '{tbp_pkg::MODE_CHOOSER, tbp_pkg::MODE_LOCAL, tbp_pkg::MODE_CHOOSER,
                    MODE_FALL_LO, MODE_FALL_HI, tbp_pkg::MODE_CHOOSER};
    for (int i = 0; i < POOL_SIZE; i++) begin
      pc_pool[i] = {$urandom, $urandom};
      periods[i] = $urandom_range(0, 6);
      trips[i]   = 0;
    end
    clear_predictor();

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    // tables are cleared after reset; wait for the first ready
    while (!s_tready) @(posedge clk);
    set_mode(tbp_pkg::MODE_CHOOSER);

    for (int i = 0; i < NUM_ROWS; i++) begin
      if (dir_rows[i].mode != model_mode) set_mode(dir_rows[i].mode);
      push_branch(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want, seen);
    end

    for (int p = 0; p < 6; p++) begin
      set_mode(phase_modes[p]);
      quiet = (p == 2);
      n = 0;
      while (n < ITEMS_PER_PHASE) begin
        if ($urandom_range(0, 99) < 80) begin
          // lookup, then resolve it with the opinions it returned
          slot = $urandom_range(0, POOL_SIZE - 1);
          it = '{tbp_pkg::KIND_PREDICT, pc_pool[slot], 1'($urandom), 1'($urandom),
                 1'($urandom)};
          push_branch(it, 1'b0, ZERO_RES, seen);
          if (periods[slot] == 0)
            outcome = 1'b1;
          else
            outcome = ((trips[slot] % periods[slot]) != periods[slot] - 1);
          trips[slot]++;
          it = '{tbp_pkg::KIND_UPDATE, pc_pool[slot], outcome, seen.local_says_taken,
                 seen.global_says_taken};
          push_branch(it, 1'b0, ZERO_RES, seen);
          n += 2;
        end else begin
          it = '{1'($urandom), {$urandom, $urandom}, 1'($urandom), 1'($urandom),
                 1'($urandom)};
          push_branch(it, 1'b0, ZERO_RES, seen);
          n += 1;
        end
      end
    end
    quiet = 1'b0;

    drain_block(20);

    sat_local  = 0;
    sat_global = 0;
    for (int i = 0; i < tbp_pkg::LOCAL_DEPTH; i++)
      if (local_ctr[i] == tbp_pkg::LCTR_MAX) sat_local++;
    for (int i = 0; i < tbp_pkg::GLOBAL_DEPTH; i++)
      if (global_ctr[i] == tbp_pkg::GCTR_MAX) sat_global++;
    $display("%0d lookups (%0d taken) and %0d updates over %0d mode writes",
             n_predicts, n_taken_preds, n_updates, n_mode_writes);
    $display("%0d local and %0d global counters ended saturated high, %0d mismatches",
             sat_local, sat_global, mismatches);
    if (mismatches == 0 && awaited_predictions.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### tournament_branch_predictor.f
sv/tbp_pkg.sv
sv/tournament_branch_predictor.sv
dv/tournament_branch_predictor_test.sv
